### src/crg_pkg.sv
package crg_pkg;

  localparam int CHAN_W    = 5;
  localparam int FRAC_BITS = 16;
  localparam int NUM_CHAN  = 3;
  localparam int CNT_W     = 6;
  localparam int DVD_W     = CHAN_W + FRAC_BITS;
  localparam int ACC_W     = DVD_W + 1;
  localparam int DIV_W     = CNT_W;
  localparam int STEP_W    = $clog2(DVD_W);
  localparam int COLOR_W   = 16;
  localparam int IDX_W     = 5;
  localparam int RED_POS   = 11;
  localparam int GREEN_POS = 6;

  typedef logic [CHAN_W-1:0]       chan_t;
  typedef logic [DVD_W-1:0]        dvd_t;
  typedef logic [DIV_W-1:0]        divisor_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

### src/color_gradient_interpolator_top.sv
// An accepted beat runs a bit-serial divide (ST_DIV), then issues its colors (ST_EMIT).
// Colors go out one per cycle while out_stall lets the output move; a run gives
// min(step_count, MAX_STEPS) colors, a zero step count none.
// The three channel divisions run in parallel, one quotient bit per cycle.
// A new input beat is taken only when the previous run is fully issued.
// Reset (rst, synchronous) clears the sequencer and the output valid.
module color_gradient_interpolator_top
  import crg_pkg::*;
#(
  parameter int MAX_STEPS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAN_W-1:0]  start_red,
  input  logic [CHAN_W-1:0]  start_green,
  input  logic [CHAN_W-1:0]  start_blue,
  input  logic [CHAN_W-1:0]  end_red,
  input  logic [CHAN_W-1:0]  end_green,
  input  logic [CHAN_W-1:0]  end_blue,
  input  logic [CNT_W-1:0]   step_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] packed_color,
  output logic [IDX_W-1:0]   step_index,
  output logic               last_color
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  divisor_t          last_idx;
  logic [CNT_W-1:0]  pos;
  logic              in_fire;
  logic              div_load;
  logic              div_shift;
  logic              emit;
  logic              emit_last;

  chan_t             st_chan [NUM_CHAN];
  chan_t             en_chan [NUM_CHAN];
  logic              neg     [NUM_CHAN];
  dvd_t              dividend[NUM_CHAN];
  dvd_t              quot    [NUM_CHAN];
  acc_t              acc     [NUM_CHAN];

  assign st_chan[0] = start_red;
  assign st_chan[1] = start_green;
  assign st_chan[2] = start_blue;
  assign en_chan[0] = end_red;
  assign en_chan[1] = end_green;
  assign en_chan[2] = end_blue;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign div_load  = in_fire && (step_count != '0);
  assign div_shift = (state == ST_DIV);
  assign emit      = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign emit_last = (pos == last_idx);

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    chan_t mag;

    assign mag         = (en_chan[c] < st_chan[c]) ? (st_chan[c] - en_chan[c])
                                                   : (en_chan[c] - st_chan[c]);
    assign dividend[c] = {mag, {FRAC_BITS{1'b0}}};

    crg_div u_div (
      .clk      (clk),
      .load     (div_load),
      .shift    (div_shift),
      .dividend (dividend[c]),
      .divisor  (last_idx),
      .quotient (quot[c])
    );

    always_ff @(posedge clk) begin
      if (div_load) begin
        neg[c] <= (en_chan[c] < st_chan[c]);
        acc[c] <= {1'b0, st_chan[c], {FRAC_BITS{1'b0}}};
      end else if (emit) begin
        acc[c] <= neg[c] ? (acc[c] - {1'b0, quot[c]}) : (acc[c] + {1'b0, quot[c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (div_load) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(DVD_W - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit && emit_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      step <= '0;
      pos  <= '0;
      if (int'(step_count) > MAX_STEPS) begin
        last_idx <= DIV_W'(MAX_STEPS - 1);
      end else begin
        last_idx <= DIV_W'(int'(step_count) - 1);
      end
    end else begin
      if (div_shift) begin
        step <= step + 1'b1;
      end
      if (emit) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_color <= {acc[0][ACC_W-2 -: CHAN_W], acc[1][ACC_W-2 -: CHAN_W], 1'b0,
                       acc[2][ACC_W-2 -: CHAN_W]};
      step_index   <= pos[IDX_W-1:0];
      last_color   <= emit_last;
    end
  end

endmodule

### src/crg_div.sv
module crg_div
  import crg_pkg::*;
(
  input  logic     clk,
  input  logic     load,
  input  logic     shift,
  input  dvd_t     dividend,
  input  divisor_t divisor,
  output dvd_t     quotient
);

  divisor_t         rem;
  dvd_t             dvd;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             qbit;

  // restoring division, one quotient bit per cycle in which shift is asserted
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvd <= dividend;
    end else if (shift) begin
      rem <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign quotient = dvd;

endmodule

### tb/color_gradient_interpolator_top_test.sv
`timescale 1ns / 1ps

module color_gradient_interpolator_top_test;
  import crg_pkg::*;

  localparam int MAX_STEPS = 32;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    chan_t            src[NUM_CHAN];
    chan_t            dst[NUM_CHAN];
    logic [CNT_W-1:0] steps;
  } gradient_req_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   index;
    logic               last;
  } gradient_color_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CHAN_W-1:0]  start_red = '0;
  logic [CHAN_W-1:0]  start_green = '0;
  logic [CHAN_W-1:0]  start_blue = '0;
  logic [CHAN_W-1:0]  end_red = '0;
  logic [CHAN_W-1:0]  end_green = '0;
  logic [CHAN_W-1:0]  end_blue = '0;
  logic [CNT_W-1:0]   step_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COLOR_W-1:0] packed_color;
  logic [IDX_W-1:0]   step_index;
  logic               last_color;

  gradient_req_t   pending_q[$];
  gradient_color_t gradient_q[$];
  gradient_req_t   cur_req;
  int              send_idle_pct = 15;
  int              recv_stall_pct = 57;
  int              fail_count = 0;

  color_gradient_interpolator_top #(
    .MAX_STEPS(MAX_STEPS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_red(start_red),
    .start_green(start_green),
    .start_blue(start_blue),
    .end_red(end_red),
    .end_green(end_green),
    .end_blue(end_blue),
    .step_count(step_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .packed_color(packed_color),
    .step_index(step_index),
    .last_color(last_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected colors for one accepted request, 16 fraction bits per channel
  function automatic void predict_gradient(gradient_req_t r);
    int              n;
    longint          inc[NUM_CHAN];
    longint          acc;
    chan_t           ch[NUM_CHAN];
    gradient_color_t c;
    n = r.steps;
    if (n == 0) return;
    if (n > MAX_STEPS) n = MAX_STEPS;
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (n > 1) begin
        inc[k] = ((longint'(r.dst[k]) - longint'(r.src[k])) * (longint'(1) << FRAC_BITS))
                 / longint'(n - 1);
      end else begin
        inc[k] = 0;
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        acc = (longint'(r.src[k]) << FRAC_BITS) + inc[k] * longint'(i);
        if (acc < 0) acc = 0;
        ch[k] = chan_t'(acc >> FRAC_BITS);
      end
      c.color = {ch[0], ch[1], 1'b0, ch[2]};
      c.index = IDX_W'(i);
      c.last  = (i == n - 1);
      gradient_q.push_back(c);
    end
  endfunction

  function automatic gradient_req_t make_req(int sr, int sg, int sb,
                                             int er, int eg, int eb, int n);
    gradient_req_t r;
    r.src[0] = chan_t'(sr);
    r.src[1] = chan_t'(sg);
    r.src[2] = chan_t'(sb);
    r.dst[0] = chan_t'(er);
    r.dst[1] = chan_t'(eg);
    r.dst[2] = chan_t'(eb);
    r.steps  = CNT_W'(n);
    return r;
  endfunction

  function automatic int random_chan();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 31;
    return $urandom_range(0, 31);
  endfunction

  function automatic gradient_req_t random_req();
    gradient_req_t r;
    int            pick;
    int            n;
    pick = $urandom_range(0, 99);
    if (pick < 65) n = $urandom_range(1, 8);
    else if (pick < 88) n = $urandom_range(9, 32);
    else n = $urandom_range(0, 63);
    for (int k = 0; k < NUM_CHAN; k++) begin
      r.src[k] = chan_t'(random_chan());
      r.dst[k] = chan_t'(random_chan());
    end
    r.steps = CNT_W'(n);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_gradient(cur_req);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = pending_q.pop_front();
          in_valid    <= 1'b1;
          start_red   <= cur_req.src[0];
          start_green <= cur_req.src[1];
          start_blue  <= cur_req.src[2];
          end_red     <= cur_req.dst[0];
          end_green   <= cur_req.dst[1];
          end_blue    <= cur_req.dst[2];
          step_count  <= cur_req.steps;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gradient_color_t exp_c;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gradient_q.size() == 0) begin
          $error("unexpected color beat: packed_color %h step_index %0d",
                 packed_color, step_index);
          fail_count++;
        end else begin
          exp_c = gradient_q.pop_front();
          if (packed_color !== exp_c.color) begin
            $error("packed_color: expected %h, actual %h", exp_c.color, packed_color);
            fail_count++;
          end
          if (step_index !== exp_c.index) begin
            $error("step_index: expected %0d, actual %0d", exp_c.index, step_index);
            fail_count++;
          end
          if (last_color !== exp_c.last) begin
            $error("last_color: expected %0b, actual %0b", exp_c.last, last_color);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || gradient_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    pending_q.push_back(make_req(0, 0, 0, 31, 31, 31, 32));
    pending_q.push_back(make_req(31, 31, 31, 0, 0, 0, 32));
    pending_q.push_back(make_req(7, 19, 31, 0, 25, 3, 1));
    pending_q.push_back(make_req(31, 31, 31, 31, 31, 31, 1));
    pending_q.push_back(make_req(5, 10, 15, 20, 25, 30, 0));
    pending_q.push_back(make_req(0, 31, 12, 31, 0, 12, 33));
    pending_q.push_back(make_req(31, 0, 1, 0, 31, 30, 63));
    pending_q.push_back(make_req(0, 31, 0, 31, 0, 31, 2));
    pending_q.push_back(make_req(17, 17, 17, 17, 17, 17, 17));
    pending_q.push_back(make_req(31, 0, 31, 0, 31, 0, 3));
    pending_q.push_back(make_req(31, 0, 30, 0, 31, 1, 4));
    pending_q.push_back(make_req(1, 30, 9, 30, 1, 9, 31));
    pending_q.push_back(make_req(0, 0, 0, 1, 1, 1, 32));
    pending_q.push_back(make_req(31, 31, 31, 30, 30, 30, 7));
    pending_q.push_back(make_req(10, 21, 5, 11, 20, 6, 16));
    pending_q.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(21, 10, 26, 2, 29, 4, 5));
    pending_q.push_back(make_req(0, 31, 0, 31, 0, 31, 48));
    pending_q.push_back(make_req(3, 28, 14, 29, 2, 15, 9));
    pending_q.push_back(make_req(31, 0, 16, 0, 31, 16, 32));
    wait_drained();

    for (int i = 0; i < 85; i++) pending_q.push_back(random_req());
    while (pending_q.size() > 40) @(posedge clk);
    wait_drained();

    send_idle_pct  = 57;
    recv_stall_pct = 15;
    for (int i = 0; i < 85; i++) pending_q.push_back(random_req());
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 80; i++) pending_q.push_back(random_req());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && gradient_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### color_gradient_interpolator_top.f
src/crg_pkg.sv
src/crg_div.sv
src/color_gradient_interpolator_top.sv
tb/color_gradient_interpolator_top_test.sv
